FILE: hdl/lfsc_pkg.sv
// shared constants, types and helpers for the line follow steering controller
package lfsc_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int LVL_W        = 12;
    localparam int CAL_W        = 16;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 4;
    localparam int GAIN_W       = 14;
    localparam int POS_W        = 14;
    localparam int DRV_W        = 15;
    localparam int NLVL_W       = 13;
    localparam int WSUM_W       = 18;
    localparam int OSUM_W       = 16;
    localparam int DIV_NUM_W    = 28;
    localparam int DIV_DEN_W    = 16;
    localparam int DIV_CNT_W    = 5;
    localparam int IN_DATA_W    = 104;
    localparam int OUT_DATA_W   = 48;

    localparam int FULL_LEVEL   = 4096;
    localparam int FIX_SHIFT    = 10;
    localparam int INTEG_LIMIT  = 5120;
    localparam int TURN_MAX     = 100;
    localparam int SPEED_HI     = 90;
    localparam int SPEED_LO     = 30;
    localparam int SPEED_SPAN   = SPEED_HI - SPEED_LO;
    localparam int BASE_SCALE   = 1500 / 100;
    localparam int ADJ_SCALE    = 600 / TURN_MAX;
    localparam int LOST_LIMIT   = 5;
    localparam int RECIP7       = 2341;
    localparam int RECIP7_SHIFT = 14;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANALOG     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_LO   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_HI   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_LO   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_HI   = 4'd7;

    localparam logic [CFG_W-1:0] WHITE_LO_RST = 64'd659783908251468931;
    localparam logic [CFG_W-1:0] WHITE_HI_RST = 64'd399701858682997008;
    localparam logic [CFG_W-1:0] BLACK_LO_RST = 64'd20266507565531203;
    localparam logic [CFG_W-1:0] BLACK_HI_RST = 64'd18014712046944329;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

    // divide by 1024, truncating toward zero
    function automatic logic signed [31:0] f_div_fix(input logic signed [31:0] v);
        logic signed [31:0] t;
        t = v + ((v < 0) ? 32'sd1023 : 32'sd0);
        return t >>> FIX_SHIFT;
    endfunction

endpackage

FILE: hdl/lfsc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module lfsc_div import lfsc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   c_trial;
    logic                 c_fit;

    assign c_trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign c_fit   = c_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= c_fit ? DIV_DEN_W'(c_trial - {1'b0, r_den})
                               : c_trial[DIV_DEN_W-1:0];
                r_num <= {r_num[DIV_NUM_W-2:0], c_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

FILE: hdl/line_follow_steering_controller_core.sv
// top level: sensor weighting, pid steering and drive output for a line follower
//
// One request carries a sample of eight line sensors and gives one drive result.
// Channels are worked one at a time from a shift register; in analog mode a channel
// that lies between its black and white levels is normalized by the shared 28-step
// bit-serial divider, and the line position takes one more pass through it unless
// the total weight is zero (e.g. digital mode with no line bit set), in which case
// the position division is skipped. The three pid products share one multiplier,
// one product in each of the states S_MP, S_MD and S_MI. A new request is taken
// once the previous one has finished, even while its result waits.
module line_follow_steering_controller_core import lfsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // level_ch0..level_ch7 (12 bits each), line_bits (8)
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // left_drive (15), right_drive (15), line_position (14), lost_override (1), zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CH, S_CHW, S_POS, S_POSW, S_MP, S_MD, S_MI, S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [GAIN_W-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic              r_analog;
    logic [CFG_W-1:0]  r_white_lo, r_white_hi, r_black_lo, r_black_hi;

    // controller state
    logic signed [POS_W-1:0] r_integ, r_prev_err, r_prev_pos, r_pos;
    logic [2:0]              r_lost;

    // per-item working registers
    logic [SENSOR_COUNT*LVL_W-1:0] r_lv_sh;
    logic [SENSOR_COUNT-1:0]       r_bits_sh;
    logic [SENSOR_COUNT-1:0]       r_line;
    logic [2:0]                    r_ch;
    logic signed [WSUM_W-1:0]      r_wsum;
    logic [OSUM_W-1:0]             r_osum;
    logic signed [31:0]            r_prod, r_acc;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_div_req div_req;
    t_div_rsp div_rsp;

    lfsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // channel normalization
    logic [CFG_W-1:0]  c_wh_word, c_bk_word;
    logic [CAL_W-1:0]  c_wh, c_bk, c_v;
    logic [NLVL_W-1:0] c_lv, c_lv_sel, c_b;
    logic              c_need_div, c_acc;
    logic signed [4:0] c_weight;
    logic signed [WSUM_W-1:0] c_wb;

    always_comb begin
        c_wh_word  = r_ch[2] ? r_white_hi : r_white_lo;
        c_bk_word  = r_ch[2] ? r_black_hi : r_black_lo;
        c_wh       = c_wh_word[r_ch[1:0]*CAL_W +: CAL_W];
        c_bk       = c_bk_word[r_ch[1:0]*CAL_W +: CAL_W];
        c_v        = {4'b0, r_lv_sh[LVL_W-1:0]};
        c_need_div = 1'b0;
        if (!r_analog) begin
            c_lv = r_bits_sh[0] ? '0 : NLVL_W'(FULL_LEVEL);
        end else if (c_v <= c_bk) begin
            c_lv = '0;
        end else if (c_v >= c_wh) begin
            c_lv = NLVL_W'(FULL_LEVEL);
        end else begin
            c_lv       = '0;
            c_need_div = 1'b1;
        end
        c_lv_sel = (r_state == S_CHW) ? div_rsp.quot[NLVL_W-1:0] : c_lv;
        c_b      = NLVL_W'(FULL_LEVEL) - c_lv_sel;
        c_weight = $signed({1'b0, r_ch, 1'b0}) - 5'sd7;
        c_wb     = WSUM_W'($signed({1'b0, c_b}) * c_weight);
        c_acc    = ((r_state == S_CH) && !c_need_div)
                || ((r_state == S_CHW) && div_rsp.done);
    end

    // position and integral
    logic [WSUM_W-1:0]       c_wabs;
    logic signed [POS_W-1:0] c_pos_new, c_err_new;
    logic signed [POS_W:0]   c_isum;
    logic signed [POS_W-1:0] c_integ_new;
    logic                    c_pos_done;

    always_comb begin
        c_wabs     = r_wsum[WSUM_W-1] ? WSUM_W'(-r_wsum) : WSUM_W'(r_wsum);
        c_pos_new  = r_prev_pos;
        if (r_state == S_POSW) begin
            c_pos_new = r_wsum[WSUM_W-1] ? -$signed(div_rsp.quot[POS_W-1:0])
                                         : $signed(div_rsp.quot[POS_W-1:0]);
        end
        c_pos_done = ((r_state == S_POS) && (r_osum == '0))
                  || ((r_state == S_POSW) && div_rsp.done);
        c_err_new  = -c_pos_new;
        c_isum     = (POS_W+1)'(r_integ) + (POS_W+1)'(c_err_new);
        if (c_isum > INTEG_LIMIT) begin
            c_integ_new = POS_W'(INTEG_LIMIT);
        end else if (c_isum < -INTEG_LIMIT) begin
            c_integ_new = POS_W'(-INTEG_LIMIT);
        end else begin
            c_integ_new = POS_W'(c_isum);
        end
    end

    always_comb begin
        div_req = '0;
        if ((r_state == S_CH) && c_need_div) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'({c_v[LVL_W-1:0] - c_bk[LVL_W-1:0], 12'b0});
            div_req.den   = c_wh - c_bk;
        end else if ((r_state == S_POS) && (r_osum != '0)) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'({c_wabs, 10'b0});
            div_req.den   = r_osum;
        end
    end

    // shared pid multiplier operands
    logic signed [POS_W-1:0] c_err;
    logic signed [31:0]      c_ma, c_mb;

    always_comb begin
        c_err = -r_pos;
        c_ma  = 32'($signed({1'b0, r_prop_gain}));
        c_mb  = 32'(c_err);
        unique case (r_state)
            S_MD: begin
                c_ma = 32'($signed({1'b0, r_deriv_gain}));
                c_mb = 32'(c_err) - 32'(r_prev_err);
            end
            S_MI: begin
                c_ma = 32'($signed({1'b0, r_integ_gain}));
                c_mb = 32'(r_integ);
            end
            default: begin
                c_ma = 32'($signed({1'b0, r_prop_gain}));
                c_mb = 32'(c_err);
            end
        endcase
    end

    // final steering
    logic signed [31:0]      c_sum;
    logic signed [7:0]       c_turn;
    logic [POS_W-1:0]        c_pabs;
    logic [18:0]             c_x;
    logic [8:0]              c_y;
    logic [19:0]             c_yq;
    logic [6:0]              c_speed;
    logic [3:0]              c_cnt;
    logic                    c_left, c_right, c_forced;
    logic [2:0]              c_lost_new;
    logic signed [DRV_W:0]   c_base, c_adj, c_sl, c_sr;

    always_comb begin
        c_sum  = r_acc + f_div_fix(r_prod);
        if (c_sum > TURN_MAX) begin
            c_turn = 8'(TURN_MAX);
        end else if (c_sum < -TURN_MAX) begin
            c_turn = -8'(TURN_MAX);
        end else begin
            c_turn = 8'(c_sum);
        end
        c_pabs  = r_pos[POS_W-1] ? POS_W'(-r_pos) : POS_W'(r_pos);
        c_x     = 19'(c_pabs) * 19'(SPEED_SPAN);
        c_y     = c_x[18:FIX_SHIFT];
        c_yq    = 20'(c_y) * 20'(RECIP7);
        c_speed = 7'(SPEED_HI) - 7'(c_yq[19:RECIP7_SHIFT]);
        c_cnt   = '0;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            c_cnt = c_cnt + 4'(r_line[k]);
        end
        c_left     = r_line[1:0] != '0;
        c_right    = r_line[7:6] != '0;
        c_forced   = 1'b0;
        c_lost_new = '0;
        if (c_cnt == '0) begin
            c_lost_new = (r_lost == 3'd7) ? r_lost : r_lost + 1'b1;
            if (c_lost_new > 3'(LOST_LIMIT)) begin
                c_speed  = 7'(SPEED_LO);
                c_turn   = r_pos[POS_W-1] ? 8'(TURN_MAX) : -8'(TURN_MAX);
                c_forced = 1'b1;
            end
        end else if (c_cnt <= 4'd2 && c_left && !c_right) begin
            c_speed  = 7'(SPEED_LO);
            c_turn   = 8'(TURN_MAX);
            c_forced = 1'b1;
        end else if (c_cnt <= 4'd2 && c_right && !c_left) begin
            c_speed  = 7'(SPEED_LO);
            c_turn   = -8'(TURN_MAX);
            c_forced = 1'b1;
        end
        // both sums stay inside the drive limit, so no clamp is needed
        c_base = (DRV_W+1)'(c_speed) * (DRV_W+1)'(BASE_SCALE);
        c_adj  = (DRV_W+1)'(c_turn) * (DRV_W+1)'(ADJ_SCALE);
        c_sl   = c_base - c_adj;
        c_sr   = c_base + c_adj;
    end

    logic c_load;
    assign c_load = (r_state == S_FIN) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prop_gain  <= GAIN_W'(10);
            r_integ_gain <= '0;
            r_deriv_gain <= GAIN_W'(50);
            r_analog     <= 1'b0;
            r_white_lo   <= WHITE_LO_RST;
            r_white_hi   <= WHITE_HI_RST;
            r_black_lo   <= BLACK_LO_RST;
            r_black_hi   <= BLACK_HI_RST;
            r_integ      <= '0;
            r_prev_err   <= '0;
            r_prev_pos   <= '0;
            r_lost       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_PROP_GAIN:  r_prop_gain  <= i_cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN: r_integ_gain <= i_cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN: r_deriv_gain <= i_cfg_data[GAIN_W-1:0];
                    REG_ANALOG:     r_analog     <= i_cfg_data[0];
                    REG_WHITE_LO:   r_white_lo   <= i_cfg_data;
                    REG_WHITE_HI:   r_white_hi   <= i_cfg_data;
                    REG_BLACK_LO:   r_black_lo   <= i_cfg_data;
                    REG_BLACK_HI:   r_black_hi   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_m_axis_tready && !c_load) begin
                r_out_valid <= 1'b0;
            end

            if (c_acc) begin
                r_wsum    <= r_wsum + c_wb;
                r_osum    <= r_osum + OSUM_W'(c_b);
                r_lv_sh   <= r_lv_sh >> LVL_W;
                r_bits_sh <= r_bits_sh >> 1;
                r_ch      <= r_ch + 1'b1;
            end

            if (c_pos_done) begin
                r_pos   <= c_pos_new;
                r_integ <= c_integ_new;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_lv_sh   <= i_s_axis_tdata[SENSOR_COUNT*LVL_W-1:0];
                        r_bits_sh <= i_s_axis_tdata[IN_DATA_W-1 -: SENSOR_COUNT];
                        r_line    <= i_s_axis_tdata[IN_DATA_W-1 -: SENSOR_COUNT];
                        r_ch      <= '0;
                        r_wsum    <= '0;
                        r_osum    <= '0;
                        r_state   <= S_CH;
                    end
                end
                S_CH: begin
                    if (c_need_div) begin
                        r_state <= S_CHW;
                    end else if (r_ch == 3'd7) begin
                        r_state <= S_POS;
                    end
                end
                S_CHW: begin
                    if (div_rsp.done) begin
                        r_state <= (r_ch == 3'd7) ? S_POS : S_CH;
                    end
                end
                S_POS: begin
                    r_state <= (r_osum == '0) ? S_MP : S_POSW;
                end
                S_POSW: begin
                    if (div_rsp.done) begin
                        r_state <= S_MP;
                    end
                end
                S_MP: begin
                    r_prod  <= c_ma * c_mb;
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_acc   <= f_div_fix(r_prod);
                    r_prod  <= c_ma * c_mb;
                    r_state <= S_MI;
                end
                S_MI: begin
                    r_acc   <= r_acc + f_div_fix(r_prod);
                    r_prod  <= c_ma * c_mb;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (c_load) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {3'b0, c_forced, r_pos,
                                        DRV_W'(c_sr), DRV_W'(-c_sl)};
                        r_prev_err  <= c_err;
                        r_prev_pos  <= r_pos;
                        r_lost      <= c_lost_new;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

endmodule

FILE: verif/tb.sv
// self-checking testbench for the line follow steering controller core
module tb import lfsc_pkg::*; ();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 320;

    typedef struct {
        logic [DRV_W-1:0] left_drive;
        logic [DRV_W-1:0] right_drive;
        logic [POS_W-1:0] line_position;
        logic             lost_override;
    } t_steer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    line_follow_steering_controller_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // predictor copy of configuration and state
    int unsigned kp, ki, kd, analog;
    logic [CFG_W-1:0] white_lo, white_hi, black_lo, black_hi;
    int integ_acc, last_err, last_pos, lost_cnt;

    logic [IN_DATA_W-1:0] pending_samples[$];
    t_steer               expected_steer[$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  sample_taken = 0;

    initial forever #5 i_clk = ~i_clk;

    task automatic report(input string what, input int got, input int want);
        $display("error: %s got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic int cal_level(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                     input int ch);
        logic [CFG_W-1:0] w;
        w = (ch < 4) ? lo : hi;
        return int'(w[16*(ch%4) +: 16]);
    endfunction

    function automatic int clamp_sym(input int v, input int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_steer steer_predict(input logic [IN_DATA_W-1:0] td);
        t_steer r;
        logic [7:0] bits;
        int wsum, osum, pos, err, turn, speed, adj, sl, sr, cnt, b, lv, v, wh, bk;
        longint p, d, ig;
        bit forced, left, right;
        bits = td[96 +: 8];
        wsum = 0; osum = 0; cnt = 0; forced = 0;
        for (int ch = 0; ch < SENSOR_COUNT; ch++) begin
            if (analog != 0) begin
                v = int'(td[ch*LVL_W +: LVL_W]);
                wh = cal_level(white_lo, white_hi, ch);
                bk = cal_level(black_lo, black_hi, ch);
                if (v <= bk) lv = 0;
                else if (v >= wh) lv = FULL_LEVEL;
                else lv = (v - bk) * FULL_LEVEL / (wh - bk);
            end else begin
                lv = bits[ch] ? 0 : FULL_LEVEL;
            end
            b = FULL_LEVEL - lv;
            wsum += 1024 * b * (2 * ch - 7);
            osum += b;
            if (bits[ch]) cnt++;
        end
        pos = (osum != 0) ? wsum / osum : last_pos;
        err = -pos;
        integ_acc = clamp_sym(integ_acc + err, INTEG_LIMIT);
        p = (longint'(kp) * err) / 1024;
        d = (longint'(kd) * (err - last_err)) / 1024;
        ig = (longint'(ki) * integ_acc) / 1024;
        p = p + d + ig;
        if (p > TURN_MAX) p = TURN_MAX;
        if (p < -TURN_MAX) p = -TURN_MAX;
        turn = int'(p);
        last_err = err;
        speed = SPEED_HI - SPEED_SPAN * (pos < 0 ? -pos : pos) / 7168;
        if (speed < SPEED_LO) speed = SPEED_LO;
        left = (bits & 8'h03) != 0;
        right = (bits & 8'hC0) != 0;
        if (cnt == 0) begin
            if (lost_cnt < 7) lost_cnt++;
            if (lost_cnt > LOST_LIMIT) begin
                speed = SPEED_LO;
                turn = (pos < 0) ? TURN_MAX : -TURN_MAX;
                forced = 1;
            end
        end else begin
            lost_cnt = 0;
            if (cnt <= 2 && left && !right) begin
                speed = SPEED_LO; turn = TURN_MAX; forced = 1;
            end else if (cnt <= 2 && right && !left) begin
                speed = SPEED_LO; turn = -TURN_MAX; forced = 1;
            end
        end
        adj = turn * 600 / TURN_MAX;
        sl = clamp_sym(speed * 1500 / 100 - adj, 9999);
        sr = clamp_sym(speed * 1500 / 100 + adj, 9999);
        last_pos = pos;
        r.left_drive = DRV_W'(-sl);
        r.right_drive = DRV_W'(sr);
        r.line_position = POS_W'(pos);
        r.lost_override = forced;
        return r;
    endfunction

    function automatic bit idle_now();
        if (cycles > 20000 && cycles < 45000) return 0;
        return $urandom_range(99) < 20;
    endfunction

    // sample input side and result side at the rising edge
    always @(posedge i_clk) begin
        t_steer e, g;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("line_follow_steering_controller_core: mismatch");
            $finish;
        end
        sample_taken = s_tvalid && s_tready && i_rst_n;
        if (sample_taken) expected_steer.push_back(steer_predict(s_tdata));
        if (i_rst_n && m_tvalid && m_tready) begin
            g.left_drive = m_tdata[0 +: DRV_W];
            g.right_drive = m_tdata[15 +: DRV_W];
            g.line_position = m_tdata[30 +: POS_W];
            g.lost_override = m_tdata[44];
            if (expected_steer.size() == 0) begin
                report("unexpected result, left_drive", int'(signed'(g.left_drive)), 0);
            end else begin
                e = expected_steer.pop_front();
                if (g.left_drive !== e.left_drive)
                    report("left_drive", int'(signed'(g.left_drive)),
                           int'(signed'(e.left_drive)));
                if (g.right_drive !== e.right_drive)
                    report("right_drive", int'(signed'(g.right_drive)),
                           int'(signed'(e.right_drive)));
                if (g.line_position !== e.line_position)
                    report("line_position", int'(signed'(g.line_position)),
                           int'(signed'(e.line_position)));
                if (g.lost_override !== e.lost_override)
                    report("lost_override", int'(g.lost_override), int'(e.lost_override));
            end
        end
    end

    // request driver and result-side stall
    always @(negedge i_clk) begin
        logic                 nv;
        logic [IN_DATA_W-1:0] nd;
        nv = s_tvalid;
        nd = s_tdata;
        if (i_rst_n) begin
            if (!s_tvalid || sample_taken) begin
                if (pending_samples.size() != 0 && !idle_now()) begin
                    nd = pending_samples.pop_front();
                    nv = 1'b1;
                end else begin
                    nv = 1'b0;
                end
            end
            m_tready <= !idle_now();
        end
        sample_taken = 0;
        s_tvalid <= nv;
        s_tdata <= nd;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            REG_PROP_GAIN:  kp = 32'(val[GAIN_W-1:0]);
            REG_INTEG_GAIN: ki = 32'(val[GAIN_W-1:0]);
            REG_DERIV_GAIN: kd = 32'(val[GAIN_W-1:0]);
            REG_ANALOG:     analog = 32'(val[0]);
            REG_WHITE_LO:   white_lo = val;
            REG_WHITE_HI:   white_hi = val;
            REG_BLACK_LO:   black_lo = val;
            REG_BLACK_HI:   black_hi = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !s_tvalid && expected_steer.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [IN_DATA_W-1:0] make_sample(input logic [7:0] bits,
                                                         input logic [11:0] lvl);
        logic [IN_DATA_W-1:0] t;
        for (int ch = 0; ch < SENSOR_COUNT; ch++) t[ch*LVL_W +: LVL_W] = lvl;
        t[96 +: 8] = bits;
        return t;
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_sample();
        logic [IN_DATA_W-1:0] t;
        logic [7:0] bits;
        int k;
        for (int ch = 0; ch < SENSOR_COUNT; ch++)
            t[ch*LVL_W +: LVL_W] = LVL_W'($urandom_range(4095));
        k = $urandom_range(9);
        if (k < 3) bits = 8'h00;
        else if (k < 6) bits = 8'($urandom_range(255));
        else if (k < 8) bits = 8'(1 << $urandom_range(7));
        else bits = 8'(3 << $urandom_range(6));
        t[96 +: 8] = bits;
        return t;
    endfunction

    function automatic logic [CFG_W-1:0] rand_cal(input bit is_white, input logic [CFG_W-1:0] blk);
        logic [CFG_W-1:0] w;
        int bk;
        for (int c = 0; c < 4; c++) begin
            if ($urandom_range(9) == 0) begin
                w[16*c +: 16] = 16'($urandom_range(65535));
            end else if (is_white) begin
                bk = int'(blk[16*c +: 16]);
                w[16*c +: 16] = (bk < 4000) ? 16'($urandom_range(4095, bk + 1)) : 16'd4095;
            end else begin
                w[16*c +: 16] = 16'($urandom_range(2000));
            end
        end
        return w;
    endfunction

    function automatic int rand_gain();
        int k;
        k = $urandom_range(5);
        if (k == 0) return 0;
        if (k == 1) return 10000;
        return $urandom_range(10000);
    endfunction

    initial begin
        logic [CFG_W-1:0] b;
        kp = 10; ki = 0; kd = 50; analog = 0;
        white_lo = WHITE_LO_RST; white_hi = WHITE_HI_RST;
        black_lo = BLACK_LO_RST; black_hi = BLACK_HI_RST;
        integ_acc = 0; last_err = 0; last_pos = 0; lost_cnt = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // digital mode at reset values: lost run, edges, center, full bar
        repeat (7) pending_samples.push_back(make_sample(8'h00, 12'h000));
        pending_samples.push_back(make_sample(8'h01, 12'hFFF));
        pending_samples.push_back(make_sample(8'h03, 12'h000));
        pending_samples.push_back(make_sample(8'h80, 12'hFFF));
        pending_samples.push_back(make_sample(8'hC0, 12'h000));
        pending_samples.push_back(make_sample(8'h18, 12'hFFF));
        pending_samples.push_back(make_sample(8'hFF, 12'h000));
        pending_samples.push_back(make_sample(8'h81, 12'hFFF));
        pending_samples.push_back(make_sample(8'h07, 12'h000));
        drain();

        // analog: channel 0 white not above black, channel 7 a window of 0 to 16'hFFFF, others a normal window
        write_reg(REG_PROP_GAIN, 64'd10000);
        write_reg(REG_INTEG_GAIN, 64'd10000);
        write_reg(REG_DERIV_GAIN, 64'd10000);
        write_reg(REG_ANALOG, 64'd1);
        write_reg(REG_BLACK_LO, {16'd200, 16'd200, 16'd200, 16'd900});
        write_reg(REG_WHITE_LO, {16'd3500, 16'd3500, 16'd3500, 16'd900});
        write_reg(REG_BLACK_HI, {16'd0, 16'd200, 16'd200, 16'd200});
        write_reg(REG_WHITE_HI, {16'hFFFF, 16'd3500, 16'd3500, 16'd3500});
        pending_samples.push_back(make_sample(8'h18, 12'h000));
        pending_samples.push_back(make_sample(8'h18, 12'hFFF));
        pending_samples.push_back(make_sample(8'h00, 12'd900));
        pending_samples.push_back(make_sample(8'h01, 12'd2000));
        repeat (4) pending_samples.push_back(rand_sample());
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_PROP_GAIN, CFG_W'(rand_gain()));
            write_reg(REG_INTEG_GAIN, CFG_W'(rand_gain()));
            write_reg(REG_DERIV_GAIN, CFG_W'(rand_gain()));
            write_reg(REG_ANALOG, CFG_W'(ph % 3 != 0));
            b = rand_cal(0, '0);
            write_reg(REG_BLACK_LO, b);
            write_reg(REG_WHITE_LO, rand_cal(1, b));
            b = rand_cal(0, '0);
            write_reg(REG_BLACK_HI, b);
            write_reg(REG_WHITE_HI, rand_cal(1, b));
            repeat (50) pending_samples.push_back(rand_sample());
            drain();
        end

        if (mismatches == 0) begin
            $display("line_follow_steering_controller_core: match");
        end else begin
            $display("line_follow_steering_controller_core: mismatch");
        end
        $finish;
    end
endmodule

FILE: sim.f
hdl/lfsc_pkg.sv
hdl/lfsc_div.sv
hdl/line_follow_steering_controller_core.sv
verif/tb.sv
